// ===== src/isodir_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package isodir_pkg;

   localparam int unsigned OFFSET_W     = 20;
   localparam int unsigned SECTOR_BYTES = 2048;
   localparam int unsigned SECTOR_BITS  = $clog2(SECTOR_BYTES);
   localparam int unsigned NAME_CHARS   = 16;
   localparam int unsigned NAME_SLOTS   = 16;
   localparam int unsigned NAME_IDX_W   = $clog2(NAME_SLOTS);
   localparam int unsigned CSR_DATA_W   = 64;
   localparam int unsigned NAME_LEN_W   = 5;

   localparam logic [OFFSET_W-1:0] OFFSET_MAX   = '1;
   localparam logic [OFFSET_W-1:0] IDENT_LEN_POS = OFFSET_W'(32);
   localparam logic [OFFSET_W-1:0] IDENT_POS     = OFFSET_W'(33);
   localparam logic [OFFSET_W:0]   WALK_MIN      = (OFFSET_W + 1)'(34);
   localparam logic [8:0]          IDENT_BASE    = 9'd33;
   localparam logic [7:0]          SEMICOLON     = 8'h3B;

   typedef enum logic [1:0] {
      CSR_NAME_LOW  = 2'd0,
      CSR_NAME_HIGH = 2'd1,
      CSR_NAME_LEN  = 2'd2,
      CSR_DIR_LEN   = 2'd3
   } csr_index_type;

   function automatic logic [7:0] to_upper(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= 8'h61 && c <= 8'h7A) begin
         r = c - 8'h20;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== src/isodir_char_match.sv =====
`timescale 1ns / 1ps
`default_nettype none

module isodir_char_match
   import isodir_pkg::*;
(
   input  wire logic [CSR_DATA_W-1:0] name_low,
   input  wire logic [CSR_DATA_W-1:0] name_high,
   input  wire logic [NAME_LEN_W-1:0] name_length,
   input  wire logic [7:0]            char_index,
   input  wire logic [7:0]            dir_byte,
   output logic                       char_bad
);

   logic [2*CSR_DATA_W-1:0] name_all;
   logic [7:0]              name_char;
   logic                    char_exists;
   logic                    char_needed;

   assign name_all    = {name_high, name_low};
   assign name_char   = name_all[char_index[NAME_IDX_W-1:0]*8 +: 8];
   assign char_exists = (char_index < 8'(NAME_CHARS)) && (char_index < 8'(NAME_SLOTS));
   assign char_needed = char_index < {3'b000, name_length};

   assign char_bad = char_needed &&
                     (!char_exists || (to_upper(name_char) != to_upper(dir_byte)));

endmodule

`default_nettype wire

// ===== src/iso9660_root_dir_name_lookup.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Direction | Beat contents
// req_      | in        | dir_byte, last_byte
// rsp_      | out       | found, file_lba, file_size
// csr_      | in        | write_enable, index, write_data
//
// One directory byte is taken every cycle unless a stalled result holds it; a byte
// producing a result goes through the input register, then the result register.
// Reset is synchronous and clears the handshake state, the walk state and the
// registers written through the csr port.
// A stalled result holds only a byte that produces a result; other bytes go on.

module iso9660_root_dir_name_lookup
   import isodir_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [7:0]            req_dir_byte,
   input  wire logic                  req_last_byte,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic                       rsp_found,
   output logic [31:0]                rsp_file_lba,
   output logic [31:0]                rsp_file_size,
   input  wire logic                  csr_write_enable,
   input  wire logic [1:0]            csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_write_data
);

   logic [CSR_DATA_W-1:0] name_low_ff, name_high_ff;
   logic [NAME_LEN_W-1:0] name_length_ff;
   logic [OFFSET_W-1:0]   dir_length_ff;

   logic                  in_valid_ff;
   logic [7:0]            in_byte_ff;
   logic                  in_last_ff;

   logic [OFFSET_W-1:0]   byte_offset_ff, byte_offset_in;
   logic [OFFSET_W-1:0]   record_start_ff, record_start_in;
   logic [7:0]            record_length_ff, record_length_in;
   logic [7:0]            ident_length_ff, ident_length_in;
   logic [7:0]            trimmed_length_ff, trimmed_length_in;
   logic [31:0]           extent_lba_ff, extent_lba_in;
   logic [31:0]           extent_size_ff, extent_size_in;
   logic                  semicolon_seen_ff, semicolon_seen_in;
   logic                  char_mismatch_ff, char_mismatch_in;
   logic                  search_done_ff, search_done_in;
   logic                  walk_stopped_ff, walk_stopped_in;

   logic                  rsp_valid_ff;
   logic                  rsp_found_ff;
   logic [31:0]           rsp_lba_ff, rsp_size_ff;

   logic                  produce;
   logic                  res_found;
   logic [31:0]           res_lba, res_size;
   logic                  advance;
   logic                  out_free;
   logic                  char_bad;

   logic [OFFSET_W-1:0]   pos;
   logic                  in_walk;
   logic                  walk_end;
   logic [OFFSET_W-SECTOR_BITS-1:0] sector_index;
   logic [OFFSET_W-1:0]   next_sector;
   logic [1:0]            lane;
   logic [OFFSET_W-1:0]   ident_k;
   logic [OFFSET_W-1:0]   ident_k1;

   isodir_char_match u_char_match (
      .name_low    (name_low_ff),
      .name_high   (name_high_ff),
      .name_length (name_length_ff),
      .char_index  (trimmed_length_ff),
      .dir_byte    (in_byte_ff),
      .char_bad    (char_bad)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         name_low_ff    <= '0;
         name_high_ff   <= '0;
         name_length_ff <= '0;
         dir_length_ff  <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_NAME_LOW:  name_low_ff    <= csr_write_data;
            CSR_NAME_HIGH: name_high_ff   <= csr_write_data;
            CSR_NAME_LEN:  name_length_ff <= csr_write_data[NAME_LEN_W-1:0];
            CSR_DIR_LEN:   dir_length_ff  <= csr_write_data[OFFSET_W-1:0];
            default: ;
         endcase
      end
   end

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && (out_free || !produce);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_dir_byte;
         in_last_ff <= req_last_byte;
      end
   end

   assign pos          = byte_offset_ff - record_start_ff;
   assign in_walk      = !search_done_ff && !walk_stopped_ff &&
                         (byte_offset_ff >= record_start_ff);
   assign walk_end     = ({1'b0, record_start_ff} + WALK_MIN) > {1'b0, dir_length_ff};
   assign sector_index = record_start_ff[OFFSET_W-1:SECTOR_BITS];
   assign next_sector  = {sector_index + 1'b1, {SECTOR_BITS{1'b0}}};
   assign lane         = pos[1:0] - 2'd2;
   assign ident_k      = pos - IDENT_POS;
   assign ident_k1     = pos - IDENT_LEN_POS;

   always_comb begin
      logic       active;
      logic       decide;
      logic [8:0] need;
      logic       fits;
      logic [OFFSET_W:0] next_record;

      active      = 1'b0;
      decide      = 1'b0;
      need        = '0;
      fits        = 1'b0;
      next_record = '0;

      byte_offset_in    = byte_offset_ff;
      record_start_in   = record_start_ff;
      record_length_in  = record_length_ff;
      ident_length_in   = ident_length_ff;
      trimmed_length_in = trimmed_length_ff;
      extent_lba_in     = extent_lba_ff;
      extent_size_in    = extent_size_ff;
      semicolon_seen_in = semicolon_seen_ff;
      char_mismatch_in  = char_mismatch_ff;
      search_done_in    = search_done_ff;
      walk_stopped_in   = walk_stopped_ff;
      produce           = 1'b0;
      res_found         = 1'b0;
      res_lba           = '0;
      res_size          = '0;

      if (in_walk) begin
         active = 1'b1;
         if (pos == '0) begin
            if (walk_end) begin
               walk_stopped_in = 1'b1;
               active          = 1'b0;
            end else if (in_byte_ff == 8'h00) begin
               if (&sector_index) begin
                  walk_stopped_in = 1'b1;
               end else begin
                  record_start_in = next_sector;
               end
               active = 1'b0;
            end else begin
               record_length_in  = in_byte_ff;
               ident_length_in   = '0;
               trimmed_length_in = '0;
               extent_lba_in     = '0;
               extent_size_in    = '0;
               semicolon_seen_in = 1'b0;
               char_mismatch_in  = 1'b0;
            end
         end

         if (active && ({{(OFFSET_W-8){1'b0}}, record_length_in} > pos)) begin
            if (pos >= OFFSET_W'(2) && pos <= OFFSET_W'(5)) begin
               extent_lba_in[lane*8 +: 8] = in_byte_ff;
            end else if (pos >= OFFSET_W'(10) && pos <= OFFSET_W'(13)) begin
               extent_size_in[lane*8 +: 8] = in_byte_ff;
            end else if (pos == IDENT_LEN_POS) begin
               ident_length_in = in_byte_ff;
               decide          = in_byte_ff == 8'h00;
            end else if (pos >= IDENT_POS) begin
               if (ident_k < {{(OFFSET_W-8){1'b0}}, ident_length_ff}) begin
                  if (!semicolon_seen_ff) begin
                     if (in_byte_ff == SEMICOLON) begin
                        semicolon_seen_in = 1'b1;
                     end else begin
                        if (char_bad) begin
                           char_mismatch_in = 1'b1;
                        end
                        if (trimmed_length_ff != 8'hFF) begin
                           trimmed_length_in = trimmed_length_ff + 8'd1;
                        end
                     end
                  end
                  decide = ident_k1 == {{(OFFSET_W-8){1'b0}}, ident_length_ff};
               end
            end

            need = IDENT_BASE + {1'b0, ident_length_in};
            fits = (need <= {1'b0, record_length_in}) &&
                   (({1'b0, record_start_ff} + (OFFSET_W + 1)'(need)) <=
                    {1'b0, dir_length_ff});

            if (decide && fits && !char_mismatch_in &&
                (trimmed_length_in == {3'b000, name_length_ff})) begin
               produce        = 1'b1;
               res_found      = 1'b1;
               res_lba        = extent_lba_in;
               res_size       = extent_size_in;
               search_done_in = 1'b1;
            end

            if (!search_done_in &&
                ((pos + 1'b1) == {{(OFFSET_W-8){1'b0}}, record_length_in})) begin
               next_record = {1'b0, record_start_ff} +
                             {{(OFFSET_W-7){1'b0}}, record_length_in};
               if (next_record[OFFSET_W]) begin
                  walk_stopped_in = 1'b1;
               end else begin
                  record_start_in = next_record[OFFSET_W-1:0];
               end
            end
         end
      end

      if (in_last_ff) begin
         if (!produce && !search_done_in) begin
            produce   = 1'b1;
            res_found = 1'b0;
            res_lba   = '0;
            res_size  = '0;
         end
         byte_offset_in    = '0;
         record_start_in   = '0;
         record_length_in  = '0;
         ident_length_in   = '0;
         trimmed_length_in = '0;
         extent_lba_in     = '0;
         extent_size_in    = '0;
         semicolon_seen_in = 1'b0;
         char_mismatch_in  = 1'b0;
         search_done_in    = 1'b0;
         walk_stopped_in   = 1'b0;
      end else if (byte_offset_ff != OFFSET_MAX) begin
         byte_offset_in = byte_offset_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_offset_ff    <= '0;
         record_start_ff   <= '0;
         record_length_ff  <= '0;
         ident_length_ff   <= '0;
         trimmed_length_ff <= '0;
         extent_lba_ff     <= '0;
         extent_size_ff    <= '0;
         semicolon_seen_ff <= 1'b0;
         char_mismatch_ff  <= 1'b0;
         search_done_ff    <= 1'b0;
         walk_stopped_ff   <= 1'b0;
      end else if (advance) begin
         byte_offset_ff    <= byte_offset_in;
         record_start_ff   <= record_start_in;
         record_length_ff  <= record_length_in;
         ident_length_ff   <= ident_length_in;
         trimmed_length_ff <= trimmed_length_in;
         extent_lba_ff     <= extent_lba_in;
         extent_size_ff    <= extent_size_in;
         semicolon_seen_ff <= semicolon_seen_in;
         char_mismatch_ff  <= char_mismatch_in;
         search_done_ff    <= search_done_in;
         walk_stopped_ff   <= walk_stopped_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && produce) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && produce) begin
         rsp_found_ff <= res_found;
         rsp_lba_ff   <= res_lba;
         rsp_size_ff  <= res_size;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_found     = rsp_found_ff;
   assign rsp_file_lba  = rsp_lba_ff;
   assign rsp_file_size = rsp_size_ff;

endmodule

`default_nettype wire

// ===== src/isodir_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module isodir_checker
   import isodir_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_valid,
   input wire logic                  req_ready,
   input wire logic [7:0]            req_dir_byte,
   input wire logic                  req_last_byte,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire logic                  rsp_found,
   input wire logic [31:0]           rsp_file_lba,
   input wire logic [31:0]           rsp_file_size,
   input wire logic                  csr_write_enable,
   input wire logic [1:0]            csr_index,
   input wire logic [CSR_DATA_W-1:0] csr_write_data
);

   // A beat that reports no match carries zero location fields.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_file_lba == 32'd0 && rsp_file_size == 32'd0)
      else $error("miss beat with nonzero lba or size");

   // A stalled result beat keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found) &&
      $stable(rsp_file_lba) && $stable(rsp_file_size))
      else $error("stalled result beat changed");

   // Reset leaves no result pending.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat pending after reset");

   // With the result register empty, the input side never stalls.
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty result register");

endmodule

bind iso9660_root_dir_name_lookup isodir_checker u_isodir_checker (.*);

`default_nettype wire
